// ===== hw/rtl/mtps_pkg.sv =====
package mtps_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] mtps_value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } mtps_state_e;

  // Shift command broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } mtps_shift_t;

endpackage

// ===== hw/rtl/mtps_if.sv =====
interface mtps_in_if;
  import mtps_pkg::*;

  logic        valid;
  logic        ready;
  mtps_value_t sample_value;
  logic        ends_sequence;

  modport source (output valid, output sample_value, output ends_sequence, input ready);
  modport sink   (input valid, input sample_value, input ends_sequence, output ready);
endinterface

interface mtps_out_if;
  import mtps_pkg::*;

  logic        valid;
  logic        ready;
  mtps_value_t node_value;
  logic        final_node;
  logic        overflowed;

  modport source (output valid, output node_value, output final_node, output overflowed,
                  input ready);
  modport sink   (input valid, input node_value, input final_node, input overflowed,
                  output ready);
endinterface

// ===== hw/rtl/max_tree_postorder_stream_core.sv =====
// Channel   Direction  Payload                                   Handshake
// in_i      sink       sample_value[31:0], ends_sequence         valid / ready
// out_o     source     node_value[31:0], final_node, overflowed  valid / ready
//
// For each item the sequencer takes the transaction, pops every top entry that is smaller
// than the value, then pushes the value, or drops it when the stack is full. The item that
// ends a sequence then flushes the stack. Only one entry can leave the stack per cycle,
// through the top cell, and none while the output is stalled.
// Reset empties the stack and clears the overflow flag and the output valid.
// A stalled output holds the sequencer; input is taken only while the sequencer is idle.
module max_tree_postorder_stream_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mtps_in_if.sink  in_i,
  mtps_out_if.source out_o
);
  import mtps_pkg::*;

  // The stack is a row of cells with the top at cell 0. Each cell only talks to its
  // two neighbors, so a push or a pop is one shift of the whole row.
  mtps_value_t cell_value [STACK_DEPTH];
  logic        cell_valid [STACK_DEPTH];
  mtps_shift_t shift;

  // Sequencer state and the item under work.
  mtps_state_e state_q, state_d;
  mtps_value_t item_value_q;
  logic        item_last_q;
  logic        ovf_q, ovf_d;

  // Output register.
  logic        out_valid_q;
  mtps_value_t out_value_q;
  logic        out_final_q;
  logic        out_ovf_q;

  logic        in_take;
  logic        can_emit;
  logic        top_less;
  logic        stack_full;
  logic        last_entry;
  logic        emit;
  logic        emit_final;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      mtps_value_t up_value, down_value;
      logic        up_valid, down_valid;

      if (gi == 0) begin : g_top
        assign up_value = item_value_q;
        assign up_valid = 1'b1;
      end else begin : g_inner_up
        assign up_value = cell_value[gi-1];
        assign up_valid = cell_valid[gi-1];
      end

      if (gi == STACK_DEPTH - 1) begin : g_bottom
        assign down_value = '0;
        assign down_valid = 1'b0;
      end else begin : g_inner_down
        assign down_value = cell_value[gi+1];
        assign down_valid = cell_valid[gi+1];
      end

      mtps_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (shift),
        .up_value_i   (up_value),
        .up_valid_i   (up_valid),
        .down_value_i (down_value),
        .down_valid_i (down_valid),
        .value_o      (cell_value[gi]),
        .valid_o      (cell_valid[gi])
      );
    end
  endgenerate

  assign in_take    = in_i.valid && in_i.ready;
  assign can_emit   = !out_valid_q || out_o.ready;
  // Equal values stay on the stack: only a strictly smaller top is popped.
  assign top_less   = cell_valid[0] && (cell_value[0] < item_value_q);
  assign stack_full = cell_valid[STACK_DEPTH-1];
  // During the flush the entry in cell 0 is the last one when cell 1 is empty.
  assign last_entry = !cell_valid[1];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!top_less) begin
          state_d = item_last_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_emit && last_entry) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output logic: stack shifts, result emission and the overflow flag.
  always_comb begin
    shift      = '0;
    emit       = 1'b0;
    emit_final = 1'b0;
    ovf_d      = ovf_q;
    case (state_q)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        if (top_less) begin
          if (can_emit) begin
            shift.pop = 1'b1;
            emit      = 1'b1;
          end
        end else if (stack_full) begin
          // The arriving value is dropped; the flag sticks until the sequence ends.
          ovf_d = 1'b1;
        end else begin
          shift.push = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          shift.pop  = 1'b1;
          emit       = 1'b1;
          emit_final = last_entry;
          if (last_entry) begin
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_value_q <= in_i.sample_value;
      item_last_q  <= in_i.ends_sequence;
    end
    if (emit) begin
      out_value_q <= cell_value[0];
      out_final_q <= emit_final;
      // The flag as it stands before this cycle's update; a pop never coincides with
      // a failed push, and the flush clears the flag only after its last result.
      out_ovf_q   <= ovf_q;
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.node_value = out_value_q;
  assign out_o.final_node = out_final_q;
  assign out_o.overflowed = out_ovf_q;

endmodule

// ===== hw/rtl/mtps_cell.sv =====
module mtps_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mtps_pkg::mtps_shift_t shift_i,
  input  mtps_pkg::mtps_value_t up_value_i,
  input  logic                  up_valid_i,
  input  mtps_pkg::mtps_value_t down_value_i,
  input  logic                  down_valid_i,
  output mtps_pkg::mtps_value_t value_o,
  output logic                  valid_o
);
  import mtps_pkg::*;

  mtps_value_t value_q, value_d;
  logic        valid_q, valid_d;

  // A push moves entries away from the top, a pop moves them toward it.
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (shift_i.push) begin
      value_d = up_value_i;
      valid_d = up_valid_i;
    end else if (shift_i.pop) begin
      value_d = down_value_i;
      valid_d = down_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== dv/mtps_postorder_monitor.sv =====
`timescale 1ns / 1ps

module mtps_postorder_monitor #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtps_in_if          in_i,
  mtps_out_if         out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import mtps_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    mtps_value_t node_value;
    logic        final_node;
    logic        overflowed;
  } tree_node_t;

  // Shadow of the monotonic stack that the block keeps.
  mtps_value_t  stack_mem [STACK_DEPTH];
  int unsigned  stack_fill;
  logic         overflow_seen;
  tree_node_t   postorder_q[$];
  int unsigned  fail_count;

  // Appends the postorder nodes that one input transaction releases.
  task automatic predict_postorder(input mtps_value_t value, input logic last);
    mtps_value_t popped[$];
    while (stack_fill > 0 && stack_mem[stack_fill-1] < value) begin
      stack_fill--;
      popped.push_back(stack_mem[stack_fill]);
    end
    if (stack_fill < STACK_DEPTH) begin
      stack_mem[stack_fill] = value;
      stack_fill++;
    end else begin
      overflow_seen = 1'b1;
    end
    foreach (popped[i]) postorder_q.push_back('{popped[i], 1'b0, overflow_seen});
    if (last) begin
      while (stack_fill > 0) begin
        stack_fill--;
        postorder_q.push_back('{stack_mem[stack_fill], stack_fill == 0, overflow_seen});
      end
      overflow_seen = 1'b0;
    end
  endtask

  task automatic compare_node();
    tree_node_t got;
    tree_node_t want;
    got = '{out_i.node_value, out_i.final_node, out_i.overflowed};
    if (postorder_q.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit)
        $display("%0t: unexpected node: value=%0d final=%0b overflowed=%0b", $realtime,
                 got.node_value, got.final_node, got.overflowed);
    end else begin
      want = postorder_q.pop_front();
      if (got.node_value !== want.node_value || got.final_node !== want.final_node ||
          got.overflowed !== want.overflowed) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("%0t: node differs: expected value=%0d final=%0b overflowed=%0b, got value=%0d final=%0b overflowed=%0b",
                   $realtime, want.node_value, want.final_node, want.overflowed,
                   got.node_value, got.final_node, got.overflowed);
      end
    end
  endtask

  // Results are checked before the input of the same edge is predicted, since a
  // result can never belong to a transaction taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_fill = 0;
      overflow_seen = 1'b0;
      postorder_q.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_i.valid && out_i.ready) compare_node();
      if (in_i.valid && in_i.ready) predict_postorder(in_i.sample_value, in_i.ends_sequence);
      fail_count_o <= fail_count;
      pending_o <= postorder_q.size();
    end
  end

endmodule

// ===== dv/max_tree_postorder_stream_core_tb.sv =====
`timescale 1ns / 1ps

module max_tree_postorder_stream_core_tb;
  import mtps_pkg::*;

  localparam int unsigned StackDepth  = 32;
  localparam int unsigned TotalItems  = 470;
  // The final stretch of items runs with neither sender gaps nor receiver stalls.
  localparam int unsigned QuietItems  = 80;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned StallLimit  = 2000;
  // A full flush plus its pops is the longest the block can stay busy on one item.
  localparam int unsigned DrainCycles = 2 * StackDepth + 8;

  // Shapes of random sequences. Each one steers the stack into a different corner.
  typedef enum int {
    SEQ_WIDE,     // full-range random values
    SEQ_NARROW,   // tiny range, so equal values are common
    SEQ_DESCEND,  // non-increasing runs that fill the stack and overflow it
    SEQ_CORNER,   // extreme values mixed with random ones
    SEQ_ASCEND    // non-decreasing runs, so most items pop the previous one
  } seq_shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          gaps_on;

  mtps_in_if  in_if ();
  mtps_out_if out_if ();

  max_tree_postorder_stream_core #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // The monitor predicts the postorder and compares every result transaction;
  // the top only generates traffic and reports the verdict.
  mtps_postorder_monitor #(
    .STACK_DEPTH(StackDepth)
  ) u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("max_tree_postorder_stream_core: mismatch");
          $finish;
        end
      end
    end
  end

  // Receiver: ready stays high for a random stretch, then, while gaps are on, may drop for
  // a burst of random length. Each step sees at most one assignment to ready.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  // Presents one input transaction and waits until the block takes it. Valid is
  // left high afterwards, so back-to-back items are presented without a gap.
  task automatic send_item(input mtps_value_t value, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.sample_value  <= value;
    in_if.ends_sequence <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Holds the input off until every predicted node has come out. The extra edge
  // lets the monitor account for the transaction taken at the last handshake.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic mtps_value_t corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return $urandom();
    endcase
  endfunction

  // Sends one complete sequence; its final item carries the end marker.
  task automatic send_sequence(input seq_shape_e shape);
    int unsigned len;
    mtps_value_t value;
    case (shape)
      SEQ_WIDE:    len = $urandom_range(1, 10);
      SEQ_NARROW:  len = $urandom_range(1, 12);
      SEQ_DESCEND: len = $urandom_range(StackDepth + 1, StackDepth + 8);
      SEQ_CORNER:  len = $urandom_range(1, 8);
      default:     len = $urandom_range(1, 20);
    endcase
    value = int'($urandom_range(0, 2000)) - 1000;
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        SEQ_WIDE:   value = $urandom();
        SEQ_NARROW: value = int'($urandom_range(0, 6)) - 3;
        SEQ_DESCEND: begin
          // Mostly a non-increasing run; an occasional rise pops part of the
          // stack so that overflow also follows a partial unwind.
          if (k > 0) begin
            if ($urandom_range(0, 9) == 0) value = value + int'($urandom_range(1, 50));
            else value = value - int'($urandom_range(0, 2));
          end
        end
        SEQ_CORNER: value = corner_value();
        default: begin
          if (k > 0) value = value + int'($urandom_range(0, 3));
        end
      endcase
      send_item(value, k == len - 1);
    end
  endtask

  initial begin
    seq_shape_e shape;
    int unsigned pick;

    in_if.valid         <= 1'b0;
    in_if.sample_value  <= '0;
    in_if.ends_sequence <= 1'b0;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Most negative value popped by the most positive one.
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b1);
    // A sequence of one item still yields a single, final node.
    send_item(-1, 1'b1);
    // Equal values are never popped by each other; the later copy comes first.
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b1);
    // Extremes repeated, so that equality holds at both ends of the range.
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b1);
    // A mixed sequence with nested subtrees and a repeated maximum.
    send_item(3, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(-1, 1'b0);
    send_item(7, 1'b0);
    send_item(0, 1'b0);
    send_item(7, 1'b1);

    // The sender holds off here until the block has delivered everything.
    wait_for_drain();

    while (items_sent < TotalItems) begin
      if (items_sent >= TotalItems - QuietItems) gaps_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick <= 2)      shape = SEQ_WIDE;
      else if (pick <= 4) shape = SEQ_NARROW;
      else if (pick == 5) shape = SEQ_DESCEND;
      else if (pick <= 7) shape = SEQ_CORNER;
      else                shape = SEQ_ASCEND;
      send_sequence(shape);
      if (gaps_on && $urandom_range(0, 11) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("max_tree_postorder_stream_core: match");
    end else begin
      $display("max_tree_postorder_stream_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mtps_pkg.sv
hw/rtl/mtps_if.sv
hw/rtl/mtps_cell.sv
hw/rtl/max_tree_postorder_stream_core.sv
dv/mtps_postorder_monitor.sv
dv/max_tree_postorder_stream_core_tb.sv
